// ===== rtl/frame_bitmap_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// Frame bitmap allocator assertion macros
// Shared property shapes for the checker of the frame bitmap allocator.
// ----------------------------------------------------------------------------
`ifndef FRAME_BITMAP_ALLOCATOR_DEFINES_SVH
`define FRAME_BITMAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define FBA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame bitmap allocator check failed");

// Next-cycle implication, disabled while reset is low.
`define FBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame bitmap allocator check failed");

`endif

// ===== rtl/fba_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame bitmap allocator package
// Types, codes, constants and helper functions shared by the allocator files.
// ----------------------------------------------------------------------------
package fba_pkg;

    localparam int DEF_BITMAP_WORDS = 1024;
    localparam int CFG_W            = 11;
    localparam int WORD_BITS        = 32;
    localparam int FRAME_SHIFT      = 12;
    localparam logic [31:0] WORD_FULL = 32'hFFFF_FFFF;

    typedef enum logic {
        CMD_FIND    = 1'b0,
        CMD_ACQUIRE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_FREE    = 2'd1,
        ST_MISALIGNED = 2'd2,
        ST_BEYOND     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FIND_SUM,
        S_FIND_WORD,
        S_ACQ,
        S_DONE
    } t_state;

    // Address width of a memory with the given number of entries.
    function automatic int addr_w(input int depth);
        int w;
        begin
            w = (depth > 1) ? $clog2(depth) : 1;
            return w;
        end
    endfunction

    // Index of the lowest set bit; zero when no bit is set.
    function automatic logic [4:0] lowest_set(input logic [31:0] v);
        logic [4:0] idx;
        begin
            idx = '0;
            for (int i = WORD_BITS - 1; i >= 0; i--) begin
                if (v[i]) begin
                    idx = 5'(i);
                end
            end
            return idx;
        end
    endfunction

endpackage

// ===== rtl/frame_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// Frame bitmap allocator
// Bitmap of 4 KiB page frames with a find-lowest-free and an acquire command.
// ----------------------------------------------------------------------------
// The bitmap lives in one memory of 32-bit words and a second memory holds one
// full flag per bitmap word. After reset the block sweeps both memories to zero
// word by word and accepts no word during that pass (configuration writes are
// taken). A misaligned, out-of-range or uninitialized request goes from the
// idle state straight to the done state. An acquire reads the bitmap word and
// its flag word, writes back the modified bitmap word, and writes back the flag
// word when the bitmap word turns full. A find scans at least one flag word and
// at most the active word count divided by 32 and rounded up, one per cycle
// through the flag memory read port, then reads the bitmap word of the first
// free frame if there is one. One request is worked on at a time, so a read
// never overlaps a write back to the same entry. A new word is taken while a
// result still waits in the output register.
module frame_bitmap_allocator #(
    parameter int BITMAP_WORDS = fba_pkg::DEF_BITMAP_WORDS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [fba_pkg::CFG_W-1:0]   i_cfg_wdata,    // words_in_use
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [31:0]                 s_axis_tdata,   // [31:0] frame_address
    input  logic [0:0]                  s_axis_tuser,   // [0] cmd
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [31:0]                 m_axis_tdata,   // [31:0] found_address
    output logic [1:0]                  m_axis_tuser    // [1:0] status
);
    import fba_pkg::*;

    localparam int WA        = addr_w(BITMAP_WORDS);
    localparam int SUM_WORDS = (BITMAP_WORDS + WORD_BITS - 1) / WORD_BITS;
    localparam int SA        = addr_w(SUM_WORDS);
    localparam int NW        = (WA + 1 > CFG_W) ? WA + 1 : CFG_W;

    t_state             r_state, n_state;
    logic [CFG_W-1:0]   r_words_in_use;
    logic [WA-1:0]      r_clr_cnt, n_clr_cnt;
    logic [SA-1:0]      r_sidx, n_sidx;
    logic [WA-1:0]      r_widx, n_widx;
    logic [4:0]         r_bit, n_bit;
    logic [31:0]        r_res_addr, n_res_addr;
    t_status            r_res_status, n_res_status;
    logic               r_out_valid;
    logic [31:0]        r_out_addr;
    t_status            r_out_status;

    logic               out_free;
    logic               out_load;
    logic [NW-1:0]      cfg_ext;
    logic [NW-1:0]      active;
    logic               accept;
    logic [14:0]        acq_word;
    logic [WA-1:0]      acq_w;
    logic [31:0]        s_base;
    logic [31:0]        rem;
    logic [31:0]        grp_mask;
    logic [31:0]        cand;
    logic               last_grp;
    logic [SA+4:0]      cand_word;
    logic [31:0]        widx_ext;
    logic [31:0]        new_word;

    logic               bm_we, bm_re;
    logic [WA-1:0]      bm_waddr, bm_raddr;
    logic [31:0]        bm_wdata, bm_rdata;
    logic               sum_we, sum_re;
    logic [SA-1:0]      sum_waddr, sum_raddr;
    logic [31:0]        sum_wdata, sum_rdata;

    fba_ram #(.WIDTH(WORD_BITS), .DEPTH(BITMAP_WORDS)) u_bitmap_ram (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (bm_waddr),
        .i_wdata (bm_wdata),
        .i_re    (bm_re),
        .i_raddr (bm_raddr),
        .o_rdata (bm_rdata)
    );

    fba_ram #(.WIDTH(WORD_BITS), .DEPTH(SUM_WORDS)) u_full_ram (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (sum_waddr),
        .i_wdata (sum_wdata),
        .i_re    (sum_re),
        .i_raddr (sum_raddr),
        .o_rdata (sum_rdata)
    );

    // A register value above the bitmap size acts as the bitmap size.
    assign cfg_ext = NW'(r_words_in_use);
    assign active  = (cfg_ext > NW'(BITMAP_WORDS)) ? NW'(BITMAP_WORDS) : cfg_ext;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    assign acq_word = s_axis_tdata[31:17];
    assign acq_w    = WA'(acq_word);

    // Flag word r_sidx covers bitmap words r_sidx*32 .. r_sidx*32+31; only
    // those below the active count take part in the search.
    assign s_base    = 32'(r_sidx) << 5;
    assign rem       = 32'(active) - s_base;
    assign grp_mask  = (rem >= 32'(WORD_BITS)) ? WORD_FULL : ((32'd1 << rem[4:0]) - 32'd1);
    assign cand      = ~sum_rdata & grp_mask;
    assign last_grp  = (s_base + 32'(WORD_BITS)) >= 32'(active);
    assign cand_word = {r_sidx, lowest_set(cand)};

    assign widx_ext = 32'(r_widx);
    assign new_word = bm_rdata | (32'd1 << r_bit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_words_in_use <= '0;
            r_clr_cnt      <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
            if (i_cfg_we) begin
                r_words_in_use <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sidx       <= n_sidx;
        r_widx       <= n_widx;
        r_bit        <= n_bit;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        if (out_load) begin
            r_out_addr   <= r_res_addr;
            r_out_status <= r_res_status;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_clr_cnt    = r_clr_cnt;
        n_sidx       = r_sidx;
        n_widx       = r_widx;
        n_bit        = r_bit;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        out_load     = 1'b0;
        bm_we        = 1'b0;
        bm_waddr     = r_widx;
        bm_wdata     = new_word;
        bm_re        = 1'b0;
        bm_raddr     = r_widx;
        sum_we       = 1'b0;
        sum_waddr    = SA'(r_widx >> 5);
        sum_wdata    = sum_rdata | (32'd1 << widx_ext[4:0]);
        sum_re       = 1'b0;
        sum_raddr    = r_sidx;

        unique case (r_state)
            S_CLEAR: begin
                bm_we     = 1'b1;
                bm_waddr  = r_clr_cnt;
                bm_wdata  = '0;
                sum_we    = 1'b1;
                sum_waddr = SA'(r_clr_cnt >> 5);
                sum_wdata = '0;
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (r_clr_cnt == WA'(BITMAP_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_res_addr = '0;
                    if (t_cmd'(s_axis_tuser[0]) == CMD_FIND) begin
                        if (active == '0) begin
                            n_res_status = ST_NO_FREE;
                            n_state      = S_DONE;
                        end else begin
                            n_sidx    = '0;
                            sum_re    = 1'b1;
                            sum_raddr = '0;
                            n_state   = S_FIND_SUM;
                        end
                    end else if (s_axis_tdata[FRAME_SHIFT-1:0] != '0) begin
                        n_res_status = ST_MISALIGNED;
                        n_state      = S_DONE;
                    end else if (32'(acq_word) >= 32'(active)) begin
                        n_res_status = ST_BEYOND;
                        n_state      = S_DONE;
                    end else begin
                        n_widx    = acq_w;
                        n_bit     = s_axis_tdata[16:12];
                        bm_re     = 1'b1;
                        bm_raddr  = acq_w;
                        sum_re    = 1'b1;
                        sum_raddr = SA'(acq_w >> 5);
                        n_state   = S_ACQ;
                    end
                end
            end
            S_FIND_SUM: begin
                if (cand != '0) begin
                    n_widx   = WA'(cand_word);
                    bm_re    = 1'b1;
                    bm_raddr = WA'(cand_word);
                    n_state  = S_FIND_WORD;
                end else if (last_grp) begin
                    n_res_status = ST_NO_FREE;
                    n_state      = S_DONE;
                end else begin
                    n_sidx    = r_sidx + 1'b1;
                    sum_re    = 1'b1;
                    sum_raddr = r_sidx + 1'b1;
                end
            end
            S_FIND_WORD: begin
                // The flag said this word is not full, so a clear bit exists.
                n_res_addr   = 32'({r_widx, lowest_set(~bm_rdata)}) << FRAME_SHIFT;
                n_res_status = ST_OK;
                n_state      = S_DONE;
            end
            S_ACQ: begin
                bm_we        = 1'b1;
                sum_we       = (new_word == WORD_FULL);
                n_res_addr   = '0;
                n_res_status = ST_OK;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_addr;
    assign m_axis_tuser  = r_out_status;

endmodule

// ===== rtl/fba_ram.sv =====
// ----------------------------------------------------------------------------
// Frame bitmap allocator RAM
// Simple dual-port synchronous RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module fba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [fba_pkg::addr_w(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]                    i_wdata,
    input  logic                                i_re,
    input  logic [fba_pkg::addr_w(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]                    o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/fba_chk.sv =====
// ----------------------------------------------------------------------------
// Frame bitmap allocator checker
// Port-level assertions for the allocator, attached by a bind statement.
// ----------------------------------------------------------------------------
`include "frame_bitmap_allocator_defines.svh"

module fba_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    import fba_pkg::*;

    // A stalled result word holds.
    `FBA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // Only a successful find carries an address.
    `FBA_ASSERT_SAME(a_addr_only_ok, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser != ST_OK), m_axis_tdata == 32'd0)

    // Every returned address is frame aligned.
    `FBA_ASSERT_SAME(a_addr_aligned, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[11:0] == 12'd0)

    // A result never appears right after the edge that took an input word.
    `FBA_ASSERT_SAME(a_no_early_result, i_clk, i_rst_n, $rose(m_axis_tvalid), !$past(s_axis_tvalid && s_axis_tready))

endmodule

bind frame_bitmap_allocator fba_chk u_fba_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== test/frame_bitmap_allocator_checker.sv =====
// ----------------------------------------------------------------------------
// Frame bitmap allocator checker
// Watches the register port and both stream channels, keeps its own copy of
// the frame bitmap and compares every returned word with the expected one.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_checker #(
    parameter int BITMAP_WORDS = fba_pkg::DEF_BITMAP_WORDS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [fba_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                        i_s_tvalid,
    input  logic                        i_s_tready,
    input  logic [31:0]                 i_s_tdata,
    input  logic [0:0]                  i_s_tuser,
    input  logic                        i_m_tvalid,
    input  logic                        i_m_tready,
    input  logic [31:0]                 i_m_tdata,
    input  logic [1:0]                  i_m_tuser,
    output int                          o_fail_count,
    output int                          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import fba_pkg::*;

    typedef struct {
        logic [31:0] found_address;
        t_status     status;
    } t_frame_result;

    logic [31:0]      frame_map [BITMAP_WORDS];
    logic [CFG_W-1:0] words_cfg;
    t_frame_result    pending_results [$];
    int               fail_total = 0;

    assign o_fail_count = fail_total;

    // Serves one request against the local bitmap and returns what the block
    // must answer. An acquire that succeeds marks its frame here as well.
    function automatic t_frame_result serve_frame_request(input t_cmd cmd,
                                                          input logic [31:0] addr);
        t_frame_result res;
        int unsigned   limit;
        int unsigned   w;
        int unsigned   b;
        int unsigned   frame;
        limit = (words_cfg > BITMAP_WORDS) ? BITMAP_WORDS : words_cfg;
        res.found_address = '0;
        if (cmd == CMD_FIND) begin
            w = 0;
            while (w < limit && frame_map[w] == WORD_FULL) begin
                w++;
            end
            if (w >= limit) begin
                res.status = ST_NO_FREE;
            end else begin
                b = 0;
                while (b < WORD_BITS && frame_map[w][b]) begin
                    b++;
                end
                res.found_address = 32'((w * WORD_BITS + b) << FRAME_SHIFT);
                res.status = ST_OK;
            end
        end else if (addr[FRAME_SHIFT-1:0] != '0) begin
            res.status = ST_MISALIGNED;
        end else begin
            frame = addr >> FRAME_SHIFT;
            w = frame / WORD_BITS;
            if (w >= limit) begin
                res.status = ST_BEYOND;
            end else begin
                frame_map[w][frame % WORD_BITS] = 1'b1;
                res.status = ST_OK;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_frame_result want;
        if (!i_rst_n) begin
            foreach (frame_map[i]) begin
                frame_map[i] = '0;
            end
            words_cfg = '0;
            pending_results.delete();
        end else begin
            if (i_cfg_we) begin
                words_cfg = i_cfg_wdata;
            end
            if (i_m_tvalid && i_m_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result word with nothing expected: found_address 0x%08h status %0d",
                           i_m_tdata, i_m_tuser);
                    fail_total++;
                end else begin
                    want = pending_results.pop_front();
                    if (i_m_tdata !== want.found_address) begin
                        $error("found_address: expected 0x%08h, got 0x%08h",
                               want.found_address, i_m_tdata);
                        fail_total++;
                    end
                    if (i_m_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_m_tuser);
                        fail_total++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                pending_results.push_back(serve_frame_request(t_cmd'(i_s_tuser[0]),
                                                              i_s_tdata));
            end
        end
        o_outstanding <= pending_results.size();
    end

endmodule

// ===== test/frame_bitmap_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// Frame bitmap allocator testbench
// Drives find and acquire requests under several word counts, with random
// gaps and back-pressure, and leaves the checking to the checker module.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fba_pkg::*;

    localparam int BITMAP_WORDS = DEF_BITMAP_WORDS;
    localparam int CYCLE_LIMIT  = 250000;
    localparam int END_CYCLES   = 40;
    localparam int PHASES       = 9;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [31:0]      s_axis_tdata = '0;    // [31:0] frame_address
    logic [0:0]       s_axis_tuser = '0;    // [0] cmd
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [31:0]      m_axis_tdata;         // [31:0] found_address
    logic [1:0]       m_axis_tuser;         // [1:0] status

    int fail_count;
    int outstanding;
    bit idling = 1'b1;
    int ready_hold = 0;

    always #5 i_clk = ~i_clk;

    frame_bitmap_allocator #(
        .BITMAP_WORDS (BITMAP_WORDS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    frame_bitmap_allocator_checker #(
        .BITMAP_WORDS (BITMAP_WORDS)
    ) checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tuser     (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // Result side back-pressure in random bursts while idling is set.
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            m_axis_tready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else if (idling && $urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            ready_hold <= $urandom_range(0, 4);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic write_words_in_use(input logic [CFG_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (outstanding != 0);
    endtask

    task automatic send_request(input t_cmd cmd, input logic [31:0] addr);
        if (idling && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= addr;
        s_axis_tuser <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
    endtask

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        int unsigned phase_cfg [PHASES];
        int unsigned phase_len [PHASES];
        int unsigned active;
        int unsigned frames;
        int unsigned frame;
        int unsigned pick;
        logic [31:0] addr;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Uninitialized bitmap: nothing to find, every acquire is out of range
        // unless it is misaligned first.
        write_words_in_use('0);
        send_request(CMD_FIND, 32'h0000_0000);
        send_request(CMD_ACQUIRE, 32'h0000_0000);
        send_request(CMD_ACQUIRE, 32'hFFFF_FFFF);
        send_request(CMD_ACQUIRE, 32'h0000_0001);
        wait_results_drained();

        // An oversized count acts as the full bitmap.
        write_words_in_use(11'h7FF);
        send_request(CMD_FIND, 32'hFFFF_FFFF);
        send_request(CMD_ACQUIRE, 32'h0000_0000);
        send_request(CMD_ACQUIRE, 32'h0000_0000);
        send_request(CMD_FIND, 32'h0000_0000);
        send_request(CMD_ACQUIRE, 32'hFFFF_F000);
        send_request(CMD_ACQUIRE, 32'h07FF_F000);
        send_request(CMD_ACQUIRE, 32'h0800_0000);
        send_request(CMD_ACQUIRE, 32'h0000_0800);
        send_request(CMD_ACQUIRE, 32'h0000_1000);
        send_request(CMD_FIND, 32'h0000_0000);
        wait_results_drained();

        write_words_in_use(11'd1024);
        send_request(CMD_ACQUIRE, 32'h07FF_F000);
        send_request(CMD_ACQUIRE, 32'h07FF_F001);
        send_request(CMD_FIND, 32'h0000_0000);
        wait_results_drained();

        write_words_in_use(11'd1);
        send_request(CMD_ACQUIRE, 32'h0001_F000);
        send_request(CMD_ACQUIRE, 32'h0002_0000);
        send_request(CMD_FIND, 32'h0000_0000);
        wait_results_drained();

        phase_cfg = '{1, 2, $urandom_range(3, 8), 0, 1024, 2047,
                      $urandom_range(0, 2047), 4, 33};
        phase_len = '{150, 100, 100, 40, 120, 100, 100, 90, 100};

        for (int p = 0; p < PHASES; p++) begin
            idling = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
            write_words_in_use(phase_cfg[p][CFG_W-1:0]);
            active = (phase_cfg[p] > BITMAP_WORDS) ? BITMAP_WORDS : phase_cfg[p];
            frames = active * WORD_BITS;
            for (int k = 0; k < phase_len[p]; k++) begin
                if (p == 1 && k == phase_len[p] / 2) begin
                    wait_results_drained();
                end
                pick = $urandom_range(0, 99);
                if (pick < 25) begin
                    send_request(CMD_FIND, $urandom());
                end else if (pick < 80 && frames != 0) begin
                    // Mostly low frames, so that the low words fill up and the
                    // lowest free frame keeps moving.
                    if ($urandom_range(0, 1) == 0) begin
                        frame = $urandom_range(0, ((frames < 96) ? frames : 96) - 1);
                    end else begin
                        frame = $urandom_range(0, frames - 1);
                    end
                    send_request(CMD_ACQUIRE, 32'(frame << FRAME_SHIFT));
                end else if (pick < 90) begin
                    addr = $urandom();
                    addr[FRAME_SHIFT-1:0] = '0;
                    send_request(CMD_ACQUIRE, addr);
                end else if (pick < 95 && frames != 0) begin
                    frame = $urandom_range(0, frames - 1);
                    send_request(CMD_ACQUIRE,
                                 32'(frame << FRAME_SHIFT) | 32'($urandom_range(1, 4095)));
                end else begin
                    send_request(CMD_ACQUIRE, $urandom());
                end
            end
            wait_results_drained();
        end

        repeat (END_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/fba_pkg.sv
rtl/fba_ram.sv
rtl/frame_bitmap_allocator.sv
rtl/fba_chk.sv
test/frame_bitmap_allocator_checker.sv
test/frame_bitmap_allocator_tb.sv
